// ===== rtl/aes_pkg.sv =====
// aes_pkg: shared types, register and mode codes, and the aes round functions
`default_nettype none

package aes_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_KEY_SIZE = 3'd0;
  localparam logic [2:0] CFG_MODE     = 3'd1;
  localparam logic [2:0] CFG_KEY0     = 3'd2;
  localparam logic [2:0] CFG_KEY3     = 3'd5;
  localparam logic [2:0] CFG_IV0      = 3'd6;
  localparam logic [2:0] CFG_IV1      = 3'd7;

  // mode codes
  localparam logic [3:0] MODE_ECB_ENC    = 4'd0;
  localparam logic [3:0] MODE_ECB_DEC    = 4'd1;
  localparam logic [3:0] MODE_CBC_ENC    = 4'd2;
  localparam logic [3:0] MODE_CBC_DEC    = 4'd3;
  localparam logic [3:0] MODE_CTR        = 4'd4;
  localparam logic [3:0] MODE_CFB8_ENC   = 4'd5;
  localparam logic [3:0] MODE_CFB8_DEC   = 4'd6;
  localparam logic [3:0] MODE_CFB128_ENC = 4'd7;
  localparam logic [3:0] MODE_CFB128_DEC = 4'd8;

  // error codes
  localparam logic [1:0] ERR_OK      = 2'd0;
  localparam logic [1:0] ERR_WRAP    = 2'd1;
  localparam logic [1:0] ERR_PARTIAL = 2'd2;

  localparam int RK_ROWS = 15;
  localparam logic [4:0] FULL_COUNT = 5'd16;

  typedef enum logic [1:0] {OP_NONE, OP_LOAD, OP_ROUND, OP_FINAL} rop_e;

  typedef struct packed {
    logic accept;
    rop_e op;
    logic post;
    logic bypass;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic bypass;
    logic decrypt;
    logic cfb8;
    logic byte_last;
  } dp_stat_t;

  localparam logic [2047:0] SBOX_TAB = {
    128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16};

  localparam logic [2047:0] INV_SBOX_TAB = {
    128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
    128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
    128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
    128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
    128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
    128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
    128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
    128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d};

  function automatic logic [7:0] sbox(input logic [7:0] x);
    return SBOX_TAB[8 * (255 - int'(x)) +: 8];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] x);
    return INV_SBOX_TAB[8 * (255 - int'(x)) +: 8];
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
    logic [7:0] p;
    logic [7:0] v;
    p = '0;
    v = a;
    for (int k = 0; k < 4; k++) begin
      if (b[k]) p = p ^ v;
      v = xt(v);
    end
    return p;
  endfunction

  // byte 0 of a block sits in bits 127:120
  function automatic logic [127:0] sub_shift(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    int src;
    int dst;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (inv) begin
          src = 4 * c + r;
          dst = 4 * ((c + r) & 3) + r;
          t[127 - 8 * dst -: 8] = inv_sbox(s[127 - 8 * src -: 8]);
        end else begin
          src = 4 * ((c + r) & 3) + r;
          dst = 4 * c + r;
          t[127 - 8 * dst -: 8] = sbox(s[127 - 8 * src -: 8]);
        end
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    logic [3:0] coef [4];
    logic [7:0] acc;
    if (inv) begin
      coef[0] = 4'he; coef[1] = 4'hb; coef[2] = 4'hd; coef[3] = 4'h9;
    end else begin
      coef[0] = 4'h2; coef[1] = 4'h3; coef[2] = 4'h1; coef[3] = 4'h1;
    end
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        acc = '0;
        for (int j = 0; j < 4; j++) begin
          acc = acc ^ gmul(s[127 - 8 * (4 * c + j) -: 8], coef[(4 + j - r) & 3]);
        end
        t[127 - 8 * (4 * c + r) -: 8] = acc;
      end
    end
    return t;
  endfunction

  // keep the leading cnt bytes
  function automatic logic [127:0] byte_mask(input logic [4:0] cnt);
    logic [127:0] m;
    for (int b = 0; b < 16; b++) begin
      m[127 - 8 * b -: 8] = (5'(b) < cnt) ? 8'hff : 8'h00;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/aes_block_cipher_modes.sv =====
// aes_block_cipher_modes: aes engine top level with ecb, cbc, ctr, cfb8 and cfb128 modes
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+-------------------------------------
//   in       | input     | in_valid_i/in_stall_o | data_high, data_low, byte_count, start
//   out      | output    | out_valid_o/out_stall_i | result_high, result_low, error_code
//   cfg      | input     | cfg_we_i              | cfg_index_i, cfg_data_i
//
// one beat runs nr rounds (nr = 10, 12 or 14 rounds) in the one-round-per-cycle round unit;
// cfb8 runs one cipher pass per valid byte.
// a partial ecb or cbc beat, an empty beat or an unused mode skips the rounds.
// a key or key size write starts a key schedule, input stalls meanwhile.
// a finished result waits in the output register while the next beat is taken.
// reset clears the chain, sets the counter to one and leaves the round keys unset.
`default_nettype none

module aes_block_cipher_modes import aes_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [63:0] data_high_i,
  input  wire logic [63:0] data_low_i,
  input  wire logic [4:0]  byte_count_i,
  input  wire logic        start_message_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      result_high_o,
  output logic [63:0]      result_low_o,
  output logic [1:0]       error_code_o
);

  logic         kexp_busy;
  logic [1:0]   key_size;
  logic         ram_we;
  logic [3:0]   ram_waddr;
  logic [127:0] ram_wdata;
  logic [3:0]   rk_addr;
  logic [127:0] rk;
  dp_cmd_t      cmd;
  dp_stat_t     stat;

  aes_kexp u_kexp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .busy_o      (kexp_busy),
    .key_size_o  (key_size),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata)
  );

  aes_ram #(
    .Width (128),
    .Depth (RK_ROWS)
  ) u_rk_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rk_addr),
    .rdata_o (rk)
  );

  aes_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kexp_busy_i (kexp_busy),
    .key_size_i  (key_size),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .rk_addr_o   (rk_addr)
  );

  aes_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .data_high_i     (data_high_i),
    .data_low_i      (data_low_i),
    .byte_count_i    (byte_count_i),
    .start_message_i (start_message_i),
    .cmd_i           (cmd),
    .rk_i            (rk),
    .stat_o          (stat),
    .result_high_o   (result_high_o),
    .result_low_o    (result_low_o),
    .error_code_o    (error_code_o)
  );

endmodule

`default_nettype wire

// ===== rtl/aes_ram.sv =====
// aes_ram: generic single write port ram with registered read
`default_nettype none

module aes_ram #(
  parameter int Width = 128,
  parameter int Depth = 15
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/aes_kexp.sv =====
// aes_kexp: key registers and key schedule, one word per cycle, four words per round key ram row
`default_nettype none

module aes_kexp import aes_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [2:0]   cfg_index_i,
  input  wire logic [63:0]  cfg_data_i,
  output logic              busy_o,
  output logic [1:0]        key_size_o,
  output logic              ram_we_o,
  output logic [3:0]        ram_waddr_o,
  output logic [127:0]      ram_wdata_o
);

  logic [63:0] key_q [4];
  logic [1:0]  ksize_q;
  logic [5:0]  i_q, i_d;
  logic [2:0]  j_q, j_d;
  logic [7:0]  rc_q, rc_d;
  logic [31:0] win_q [8];
  logic        busy_q, busy_d;
  logic        start;
  logic [3:0]  nk;
  logic [5:0]  last;
  logic [31:0] t, w;
  logic [63:0] kreg;

  assign start = cfg_we_i && ((cfg_index_i == CFG_KEY_SIZE) ||
                              (cfg_index_i inside {[CFG_KEY0:CFG_KEY3]}));

  always_comb begin
    case (ksize_q)
      2'd0:    begin nk = 4'd4; last = 6'd43; end
      2'd1:    begin nk = 4'd6; last = 6'd51; end
      default: begin nk = 4'd8; last = 6'd59; end
    endcase
  end

  always_comb begin
    kreg = key_q[i_q[2:1]];
    t    = win_q[0];
    rc_d = rc_q;
    if (i_q < 6'(nk)) begin
      w = i_q[0] ? kreg[31:0] : kreg[63:32];
    end else begin
      if (j_q == 3'd0) begin
        t    = sub_word({win_q[0][23:0], win_q[0][31:24]}) ^ {rc_q, 24'h0};
        rc_d = xt(rc_q);
      end else if (nk == 4'd8 && j_q == 3'd4) begin
        t = sub_word(win_q[0]);
      end
      w = win_q[3'(nk - 4'd1)] ^ t;
    end
    j_d    = (j_q == 3'(nk - 4'd1)) ? 3'd0 : j_q + 3'd1;
    i_d    = i_q + 6'd1;
    busy_d = (i_q != last);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 4; k++) key_q[k] <= '0;
      ksize_q <= '0;
      busy_q  <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      rc_q    <= 8'h01;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_KEY_SIZE) ksize_q <= cfg_data_i[1:0];
        if (cfg_index_i inside {[CFG_KEY0:CFG_KEY3]}) begin
          key_q[2'(cfg_index_i - CFG_KEY0)] <= cfg_data_i;
        end
      end
      if (start) begin
        busy_q <= 1'b1;
        i_q    <= '0;
        j_q    <= '0;
        rc_q   <= 8'h01;
      end else if (busy_q) begin
        busy_q <= busy_d;
        i_q    <= i_d;
        j_q    <= j_d;
        rc_q   <= rc_d;
      end
    end
  end

  // window of the latest words, newest first
  always_ff @(posedge clk_i) begin
    if (busy_q && !start) begin
      win_q[0] <= w;
      for (int k = 1; k < 8; k++) win_q[k] <= win_q[k-1];
    end
  end

  assign busy_o      = busy_q;
  assign key_size_o  = ksize_q;
  assign ram_we_o    = busy_q && !start && (i_q[1:0] == 2'd3);
  assign ram_waddr_o = i_q[5:2];
  assign ram_wdata_o = {win_q[2], win_q[1], win_q[0], w};

endmodule

`default_nettype wire

// ===== rtl/aes_ctrl.sv =====
// aes_ctrl: item sequencer, round schedule and output handshake
`default_nettype none

module aes_ctrl import aes_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  input  wire logic       kexp_busy_i,
  input  wire logic [1:0] key_size_i,
  input  wire dp_stat_t   stat_i,
  output dp_cmd_t         cmd_o,
  output logic [3:0]      rk_addr_o
);

  typedef enum logic [2:0] {ST_IDLE, ST_PREP, ST_RUN, ST_POST, ST_OUT} state_e;

  state_e     state_q;
  logic [3:0] k_q;
  logic       out_valid_q;
  logic [3:0] nr;
  logic [3:0] step;
  logic       out_free;

  always_comb begin
    case (key_size_i)
      2'd0:    nr = 4'd10;
      2'd1:    nr = 4'd12;
      default: nr = 4'd14;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE) || kexp_busy_i;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o     = '0;
    cmd_o.op  = OP_NONE;
    step      = k_q + 4'd1;
    rk_addr_o = stat_i.decrypt ? nr : 4'd0;
    case (state_q)
      ST_IDLE: cmd_o.accept = in_valid_i && !kexp_busy_i;
      ST_PREP: cmd_o.bypass = stat_i.bypass;
      ST_RUN: begin
        if (k_q == 4'd0)     cmd_o.op = OP_LOAD;
        else if (k_q == nr)  cmd_o.op = OP_FINAL;
        else                 cmd_o.op = OP_ROUND;
        // key row for the next cycle, read ahead through the registered ram read
        if (k_q != nr) rk_addr_o = stat_i.decrypt ? nr - step : step;
      end
      ST_POST: cmd_o.post     = 1'b1;
      ST_OUT:  cmd_o.out_load = out_free;
      default: cmd_o.op       = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: if (in_valid_i && !kexp_busy_i) state_q <= ST_PREP;
        ST_PREP: begin
          k_q     <= '0;
          state_q <= stat_i.bypass ? ST_OUT : ST_RUN;
        end
        ST_RUN: begin
          k_q <= step;
          if (k_q == nr) state_q <= ST_POST;
        end
        ST_POST: state_q <= (stat_i.cfb8 && !stat_i.byte_last) ? ST_PREP : ST_OUT;
        ST_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/aes_dp.sv =====
// aes_dp: mode registers, chaining state, round unit and result registers
`default_nettype none

module aes_dp import aes_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [2:0]   cfg_index_i,
  input  wire logic [63:0]  cfg_data_i,
  input  wire logic [63:0]  data_high_i,
  input  wire logic [63:0]  data_low_i,
  input  wire logic [4:0]   byte_count_i,
  input  wire logic         start_message_i,
  input  wire dp_cmd_t      cmd_i,
  input  wire logic [127:0] rk_i,
  output dp_stat_t          stat_o,
  output logic [63:0]       result_high_o,
  output logic [63:0]       result_low_o,
  output logic [1:0]        error_code_o
);

  logic [3:0]   mode_q;
  logic [127:0] iv_q;
  logic [127:0] d_q;
  logic [4:0]   cnt_q;
  logic [127:0] c_q, c_d;
  logic [31:0]  ctr_q, ctr_d;
  logic [127:0] st_q, st_d;
  logic [3:0]   bi_q;
  logic [127:0] res_q, res_d;
  logic [1:0]   err_q, err_d;
  logic [63:0]  out_hi_q, out_lo_q;
  logic [1:0]   out_err_q;
  logic [4:0]   cnt_in;
  logic [127:0] mask;
  logic [127:0] blk;
  logic [127:0] ss;
  logic [7:0]   cfb_byte, d_byte;
  logic         dec;

  assign cnt_in = (byte_count_i > FULL_COUNT) ? FULL_COUNT : byte_count_i;
  assign mask   = byte_mask(cnt_q);
  assign dec    = (mode_q == MODE_ECB_DEC) || (mode_q == MODE_CBC_DEC);

  assign stat_o.decrypt   = dec;
  assign stat_o.cfb8      = (mode_q == MODE_CFB8_ENC) || (mode_q == MODE_CFB8_DEC);
  assign stat_o.byte_last = ({1'b0, bi_q} == cnt_q - 5'd1);
  assign stat_o.bypass    = (mode_q <= MODE_CBC_DEC && cnt_q != FULL_COUNT) ||
                            (cnt_q == 5'd0) || (mode_q > MODE_CFB128_DEC);

  // cipher input block per mode
  always_comb begin
    case (mode_q)
      MODE_CBC_ENC: blk = d_q ^ c_q;
      MODE_CTR:     blk = {c_q[127:32], ctr_q};
      MODE_CFB8_ENC, MODE_CFB8_DEC, MODE_CFB128_ENC, MODE_CFB128_DEC: blk = c_q;
      default:      blk = d_q;
    endcase
  end

  always_comb begin
    ss = sub_shift(st_q, dec);
    case (cmd_i.op)
      OP_LOAD:  st_d = blk ^ rk_i;
      OP_ROUND: st_d = dec ? mix(ss ^ rk_i, 1'b1) : mix(ss, 1'b0) ^ rk_i;
      OP_FINAL: st_d = ss ^ rk_i;
      default:  st_d = st_q;
    endcase
  end

  always_comb begin
    d_byte = '0;
    for (int b = 0; b < 16; b++) begin
      if (4'(b) == bi_q) d_byte = d_q[127 - 8 * b -: 8];
    end
    cfb_byte = d_byte ^ st_q[127:120];
  end

  // end of item or of one cfb8 byte
  always_comb begin
    c_d   = c_q;
    ctr_d = ctr_q;
    res_d = res_q;
    err_d = err_q;
    if (cmd_i.bypass) begin
      res_d = (mode_q > MODE_CFB128_DEC) ? d_q : '0;
      err_d = (mode_q <= MODE_CBC_DEC) ? ERR_PARTIAL : ERR_OK;
    end else if (cmd_i.post) begin
      err_d = ERR_OK;
      case (mode_q)
        MODE_ECB_ENC, MODE_ECB_DEC: res_d = st_q;
        MODE_CBC_ENC: begin
          res_d = st_q;
          c_d   = st_q;
        end
        MODE_CBC_DEC: begin
          res_d = st_q ^ c_q;
          c_d   = d_q;
        end
        MODE_CTR: begin
          res_d = (d_q ^ st_q) & mask;
          if (cnt_q == FULL_COUNT) begin
            ctr_d = ctr_q + 32'd1;
            if (ctr_q == 32'hffff_ffff) err_d = ERR_WRAP;
          end
        end
        MODE_CFB8_ENC, MODE_CFB8_DEC: begin
          for (int b = 0; b < 16; b++) begin
            if (4'(b) == bi_q) res_d[127 - 8 * b -: 8] = cfb_byte;
          end
          c_d = {c_q[119:0], (mode_q == MODE_CFB8_ENC) ? cfb_byte : d_byte};
        end
        MODE_CFB128_ENC: begin
          res_d = (d_q ^ st_q) & mask;
          c_d   = (d_q ^ st_q) & mask;
        end
        MODE_CFB128_DEC: begin
          res_d = (d_q ^ st_q) & mask;
          c_d   = d_q;
        end
        default: res_d = d_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= '0;
      iv_q   <= '0;
      c_q    <= '0;
      ctr_q  <= 32'd1;
      bi_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_MODE) mode_q <= cfg_data_i[3:0];
        if (cfg_index_i == CFG_IV0)  iv_q[127:64] <= cfg_data_i;
        if (cfg_index_i == CFG_IV1)  iv_q[63:0]   <= cfg_data_i;
      end
      if (cmd_i.accept) begin
        bi_q <= '0;
        if (start_message_i) begin
          c_q   <= iv_q;
          ctr_q <= 32'd1;
        end
      end else begin
        c_q   <= c_d;
        ctr_q <= ctr_d;
        if (cmd_i.post) bi_q <= bi_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      d_q   <= {data_high_i, data_low_i} & byte_mask(cnt_in);
      cnt_q <= cnt_in;
      res_q <= '0;
      err_q <= ERR_OK;
    end else begin
      res_q <= res_d;
      err_q <= err_d;
    end
    st_q <= st_d;
    if (cmd_i.out_load) begin
      out_hi_q  <= res_q[127:64];
      out_lo_q  <= res_q[63:0];
      out_err_q <= err_q;
    end
  end

  assign result_high_o = out_hi_q;
  assign result_low_o  = out_lo_q;
  assign error_code_o  = out_err_q;

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// tb: self-checking testbench for the aes block engine, directed table then randomized messages
`timescale 1ns / 100ps

module tb;
  import aes_pkg::*;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
    logic [1:0]  err;
  } aes_res_t;

  typedef struct {
    logic [3:0]  mode;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [4:0]  cnt;
    logic        start;
    bit          typed;
    aes_res_t    res;
  } dir_row_t;

  localparam int STALL_LIMIT = 20000;
  localparam int RAND_ITEMS  = 2000;
  localparam int PHASE_ITEMS = 50;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [63:0] data_high_i = '0;
  logic [63:0] data_low_i = '0;
  logic [4:0]  byte_count_i = '0;
  logic        start_message_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [63:0] result_high_o;
  logic [63:0] result_low_o;
  logic [1:0]  error_code_o;

  aes_block_cipher_modes dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // shadow of the engine
  logic [7:0]   fwd_sb [256];
  logic [7:0]   inv_sb [256];
  logic [31:0]  sched [60];
  logic [1:0]   sh_ksize = '0;
  logic [3:0]   sh_mode = '0;
  logic [63:0]  sh_key [4] = '{default: '0};
  logic [127:0] sh_iv = '0;
  logic [127:0] sh_chain = '0;
  logic [31:0]  sh_ctr = 32'd1;

  aes_res_t result_q [$];
  int tx_pct = 0;
  int rx_pct = 0;
  int fails = 0;
  int mism = 0;
  int quiet = 0;

  function automatic logic [7:0] gfm(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = '0;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) p = p ^ a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  function automatic logic [7:0] rot8(input logic [7:0] v, input int s);
    logic [15:0] w;
    w = {v, v};
    return w[15 - s -: 8];
  endfunction

  function automatic int key_words();
    return sh_ksize == 2'd0 ? 4 : (sh_ksize == 2'd1 ? 6 : 8);
  endfunction

  function automatic logic [31:0] sub_w(input logic [31:0] w);
    return {fwd_sb[w[31:24]], fwd_sb[w[23:16]], fwd_sb[w[15:8]], fwd_sb[w[7:0]]};
  endfunction

  function automatic void expand_sched();
    int nk;
    logic [31:0] t;
    logic [7:0] rc;
    logic [63:0] r;
    nk = key_words();
    rc = 8'h01;
    for (int i = 0; i < nk; i++) begin
      r = sh_key[(i >> 1) & 3];
      sched[i] = (i & 1) ? r[31:0] : r[63:32];
    end
    for (int i = nk; i < 4 * (nk + 7) && i < 60; i++) begin
      t = sched[i - 1];
      if (i % nk == 0) begin
        t = sub_w({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = gfm(rc, 8'h02);
      end else if (nk == 8 && i % nk == 4) begin
        t = sub_w(t);
      end
      sched[i] = sched[i - nk] ^ t;
    end
  endfunction

  function automatic logic [127:0] add_rk(input logic [127:0] s, input int r);
    for (int c = 0; c < 4; c++) s[127 - 32 * c -: 32] ^= sched[(4 * r + c) % 60];
    return s;
  endfunction

  function automatic logic [127:0] subst_rows(input logic [127:0] s, input bit inv);
    logic [127:0] t;
    int a;
    int b;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        a = 4 * c + r;
        b = 4 * ((c + r) & 3) + r;
        if (inv) t[127 - 8 * b -: 8] = inv_sb[s[127 - 8 * a -: 8]];
        else t[127 - 8 * a -: 8] = fwd_sb[s[127 - 8 * b -: 8]];
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix_cols(input logic [127:0] s, input bit inv);
    logic [7:0] m [4];
    logic [127:0] t;
    logic [7:0] acc;
    if (inv) m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
    else m = '{8'h02, 8'h03, 8'h01, 8'h01};
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        acc = '0;
        for (int j = 0; j < 4; j++) acc ^= gfm(s[127 - 8 * (4 * c + j) -: 8], m[(4 + j - r) & 3]);
        t[127 - 8 * (4 * c + r) -: 8] = acc;
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] cipher(input logic [127:0] s);
    int nr;
    nr = key_words() + 6;
    s = add_rk(s, 0);
    for (int r = 1; r < nr; r++) s = add_rk(mix_cols(subst_rows(s, 0), 0), r);
    return add_rk(subst_rows(s, 0), nr);
  endfunction

  function automatic logic [127:0] inv_cipher(input logic [127:0] s);
    int nr;
    nr = key_words() + 6;
    s = add_rk(s, nr);
    for (int r = nr - 1; r > 0; r--) s = mix_cols(add_rk(subst_rows(s, 1), r), 1);
    return add_rk(subst_rows(s, 1), 0);
  endfunction

  function automatic logic [127:0] lead_mask(input int cnt);
    logic [127:0] m;
    m = '0;
    for (int b = 0; b < cnt; b++) m[127 - 8 * b -: 8] = 8'hff;
    return m;
  endfunction

  function automatic void shadow_write(input logic [2:0] idx, input logic [63:0] v);
    if (idx == CFG_KEY_SIZE) begin
      sh_ksize = v[1:0];
      expand_sched();
    end else if (idx == CFG_MODE) begin
      sh_mode = v[3:0];
    end else if (idx >= CFG_KEY0 && idx <= CFG_KEY3) begin
      sh_key[idx - CFG_KEY0] = v;
      expand_sched();
    end else if (idx == CFG_IV0) begin
      sh_iv[127:64] = v;
    end else begin
      sh_iv[63:0] = v;
    end
  endfunction

  function automatic aes_res_t predict_block(input logic [63:0] hi, input logic [63:0] lo,
                                             input logic [4:0] cnt5, input logic st);
    int cnt;
    logic [127:0] d, o, c, t, m;
    logic [7:0] ob;
    logic [1:0] err;
    aes_res_t res;
    cnt = (cnt5 > 5'd16) ? 16 : int'(cnt5);
    if (st) begin
      sh_chain = sh_iv;
      sh_ctr = 32'd1;
    end
    m = lead_mask(cnt);
    d = {hi, lo} & m;
    o = '0;
    c = sh_chain;
    err = ERR_OK;
    if (sh_mode <= MODE_CBC_DEC) begin
      if (cnt < 16) begin
        err = ERR_PARTIAL;
      end else if (sh_mode == MODE_ECB_ENC || sh_mode == MODE_CBC_ENC) begin
        t = (sh_mode == MODE_CBC_ENC) ? d ^ c : d;
        o = cipher(t);
        if (sh_mode == MODE_CBC_ENC) c = o;
      end else begin
        o = inv_cipher(d) ^ ((sh_mode == MODE_CBC_DEC) ? c : 128'h0);
        if (sh_mode == MODE_CBC_DEC) c = d;
      end
    end else if (sh_mode == MODE_CTR) begin
      if (cnt > 0) begin
        t = cipher({c[127:32], sh_ctr});
        o = (d ^ t) & m;
        if (cnt == 16) begin
          sh_ctr = sh_ctr + 32'd1;
          if (sh_ctr == 32'd0) err = ERR_WRAP;
        end
      end
    end else if (sh_mode == MODE_CFB8_ENC || sh_mode == MODE_CFB8_DEC) begin
      for (int k = 0; k < cnt; k++) begin
        t = cipher(c);
        ob = d[127 - 8 * k -: 8] ^ t[127:120];
        o[127 - 8 * k -: 8] = ob;
        c = {c[119:0], (sh_mode == MODE_CFB8_ENC) ? ob : d[127 - 8 * k -: 8]};
      end
    end else if (sh_mode == MODE_CFB128_ENC || sh_mode == MODE_CFB128_DEC) begin
      if (cnt > 0) begin
        o = (d ^ cipher(c)) & m;
        c = (sh_mode == MODE_CFB128_ENC) ? o : d;
      end
    end else begin
      o = d;
    end
    sh_chain = c;
    res.hi = o[127:64];
    res.lo = o[63:0];
    res.err = err;
    return res;
  endfunction

  // accepted results against the oldest expectation
  always @(posedge clk_i) begin
    aes_res_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (result_q.size() == 0) begin
        fails++;
        if (mism < 10) $display("unexpected result beat %h %h %0d",
                                result_high_o, result_low_o, error_code_o);
        mism++;
      end else begin
        e = result_q.pop_front();
        if (e.hi !== result_high_o || e.lo !== result_low_o || e.err !== error_code_o) begin
          fails++;
          if (mism < 10) $display("mismatch: expected %h %h %0d, got %h %h %0d",
                                  e.hi, e.lo, e.err, result_high_o, result_low_o, error_code_o);
          mism++;
        end
      end
    end
    out_stall_i <= ($urandom_range(99) < rx_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic cfg_write(input logic [2:0] idx, input logic [63:0] v);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    shadow_write(idx, v);
    @(posedge clk_i);
  endtask

  // every register, engine idle
  task automatic load_regs(input logic [1:0] ks, input logic [3:0] md,
                           input logic [63:0] k0, input logic [63:0] k1,
                           input logic [63:0] k2, input logic [63:0] k3,
                           input logic [127:0] iv);
    cfg_write(CFG_KEY_SIZE, {62'h0, ks});
    cfg_write(CFG_KEY0, k0);
    cfg_write(CFG_KEY0 + 3'd1, k1);
    cfg_write(CFG_KEY0 + 3'd2, k2);
    cfg_write(CFG_KEY3, k3);
    cfg_write(CFG_MODE, {60'h0, md});
    cfg_write(CFG_IV0, iv[127:64]);
    cfg_write(CFG_IV1, iv[63:0]);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic send_beat(input logic [63:0] hi, input logic [63:0] lo,
                           input logic [4:0] cnt, input logic st);
    while ($urandom_range(99) < tx_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_high_i <= hi;
    data_low_i <= lo;
    byte_count_i <= cnt;
    start_message_i <= st;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
  endtask

  function automatic logic [63:0] rnd64();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin
    dir_row_t rows [$];
    dir_row_t row;
    aes_res_t p;
    logic [7:0] inv;
    logic [1:0] ks;
    logic [3:0] md;
    logic [4:0] cnt;
    int sent;
    int left;
    int phase;

    for (int x = 0; x < 256; x++) begin
      inv = 8'h01;
      repeat (254) inv = gfm(inv, 8'(x));
      if (x == 0) inv = 8'h00;
      fwd_sb[x] = inv ^ rot8(inv, 1) ^ rot8(inv, 2) ^ rot8(inv, 3) ^ rot8(inv, 4) ^ 8'h63;
      inv_sb[fwd_sb[x]] = 8'(x);
    end
    for (int i = 0; i < 60; i++) sched[i] = '0;

    rows.push_back('{MODE_ECB_ENC, '1, '1, 5'd16, 1'b1, 0, '0});
    rows.push_back('{MODE_ECB_ENC, '0, '0, 5'd16, 1'b0, 0, '0});
    rows.push_back('{MODE_ECB_ENC, '1, '1, 5'd15, 1'b0, 1, '{'0, '0, ERR_PARTIAL}});
    rows.push_back('{MODE_ECB_ENC, '1, '1, 5'd0, 1'b0, 1, '{'0, '0, ERR_PARTIAL}});
    rows.push_back('{MODE_ECB_ENC, 64'h00112233_44556677, 64'h8899aabb_ccddeeff, 5'd31, 1'b0,
                     0, '0});
    rows.push_back('{MODE_ECB_DEC, '1, '0, 5'd16, 1'b0, 0, '0});
    rows.push_back('{MODE_CBC_ENC, '0, '1, 5'd16, 1'b1, 0, '0});
    rows.push_back('{MODE_CBC_ENC, '1, '0, 5'd16, 1'b0, 0, '0});
    rows.push_back('{MODE_CBC_ENC, '1, '1, 5'd1, 1'b0, 1, '{'0, '0, ERR_PARTIAL}});
    rows.push_back('{MODE_CBC_DEC, '1, '1, 5'd16, 1'b1, 0, '0});
    rows.push_back('{MODE_CBC_DEC, '0, '0, 5'd16, 1'b0, 0, '0});
    rows.push_back('{MODE_CTR, '0, '0, 5'd16, 1'b1, 0, '0});
    rows.push_back('{MODE_CTR, '1, '1, 5'd16, 1'b0, 0, '0});
    rows.push_back('{MODE_CTR, '1, '1, 5'd5, 1'b0, 0, '0});
    rows.push_back('{MODE_CTR, '1, '1, 5'd0, 1'b0, 1, '{'0, '0, ERR_OK}});
    rows.push_back('{MODE_CFB8_ENC, '1, '1, 5'd16, 1'b1, 0, '0});
    rows.push_back('{MODE_CFB8_ENC, '0, '1, 5'd3, 1'b0, 0, '0});
    rows.push_back('{MODE_CFB8_DEC, '1, '0, 5'd16, 1'b1, 0, '0});
    rows.push_back('{MODE_CFB128_ENC, '1, '1, 5'd16, 1'b1, 0, '0});
    rows.push_back('{MODE_CFB128_ENC, '1, '1, 5'd7, 1'b0, 0, '0});
    rows.push_back('{MODE_CFB128_DEC, '0, '0, 5'd16, 1'b1, 0, '0});
    rows.push_back('{MODE_CFB128_DEC, '1, '1, 5'd0, 1'b0, 1, '{'0, '0, ERR_OK}});
    rows.push_back('{4'd9, 64'h01234567_89abcdef, 64'hfedcba98_76543210, 5'd16, 1'b0,
                     1, '{64'h01234567_89abcdef, 64'hfedcba98_76543210, ERR_OK}});
    rows.push_back('{4'd15, 64'h01234567_89abcdef, 64'hfedcba98_76543210, 5'd4, 1'b1,
                     1, '{64'h01234567_00000000, 64'h0, ERR_OK}});

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    load_regs(2'd0, MODE_ECB_ENC, 64'h00010203_04050607, 64'h08090a0b_0c0d0e0f,
              64'h10111213_14151617, 64'h18191a1b_1c1d1e1f,
              128'h000102030405060708090a0b0c0d0e0f);
    @(posedge clk_i);
    tx_pct = 11;
    rx_pct = 47;
    foreach (rows[i]) begin
      row = rows[i];
      if (row.mode != sh_mode) begin
        drain();
        cfg_write(CFG_MODE, {60'h0, row.mode});
        cfg_we_i <= 1'b0;
      end
      p = predict_block(row.hi, row.lo, row.cnt, row.start);
      result_q.push_back(row.typed ? row.res : p);
      send_beat(row.hi, row.lo, row.cnt, row.start);
    end

    sent = 0;
    phase = 0;
    while (sent < RAND_ITEMS) begin
      drain();
      if (sent < RAND_ITEMS / 3) begin
        tx_pct = 11;
        rx_pct = 47;
      end else if (sent < 2 * RAND_ITEMS / 3) begin
        tx_pct = 47;
        rx_pct = 11;
      end else begin
        tx_pct = 0;
        rx_pct = 0;
      end
      ks = (phase < 4) ? 2'(phase) : 2'($urandom_range(3));
      if (phase < 16) md = 4'(phase);
      else if ($urandom_range(9) == 0) md = 4'($urandom_range(15, 9));
      else md = 4'($urandom_range(8));
      if (phase == 0)
        load_regs(ks, md, '0, '0, '0, '0, '0);
      else if (phase == 1)
        load_regs(ks, md, '1, '1, '1, '1, '1);
      else
        load_regs(ks, md, rnd64(), rnd64(), rnd64(), rnd64(), {rnd64(), rnd64()});
      @(posedge clk_i);
      left = 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        logic st;
        logic [63:0] hi, lo;
        st = (left == 0);
        if (st) left = $urandom_range(8, 1);
        left--;
        cnt = 5'd16;
        if ($urandom_range(19) == 0) cnt = 5'($urandom_range(31));
        else if (left == 0 && $urandom_range(2) == 0) cnt = 5'($urandom_range(15, 1));
        // occasional broken message: a continuation beat with no start in a fresh phase
        if (n == 0 && $urandom_range(9) == 0) st = 1'b0;
        hi = rnd64();
        lo = rnd64();
        result_q.push_back(predict_block(hi, lo, cnt, st));
        send_beat(hi, lo, cnt, st);
        sent++;
      end
      phase++;
    end

    in_valid_i <= 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fails == 0 && result_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
